FILE: rtl/rti_pkg.sv
`default_nettype none

package rti_pkg;

    // Default number format: signed Q8.12
    localparam int COORD_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF  = 12;

    // Fixed field widths
    localparam int VERTEX_W  = 60;
    localparam int EPS_W     = 12;
    localparam int DIST_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Quotient bits kept by the dividers; anything at or above 2^QUOT_BITS
    // saturates the 32-bit distance anyway.
    localparam int QUOT_BITS = DIST_W - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_ONE,
        REG_VERTEX_TWO,
        REG_VERTEX_THREE,
        REG_EPSILON
    } cfg_index_t;

    // Per-ray flags that travel beside the dividers
    typedef struct packed {
        logic det_miss;
        logic u_ovf;
        logic u_neg;
        logic v_ovf;
        logic v_neg;
        logic t_ovf;
        logic t_neg;
    } rti_side_t;

endpackage

`default_nettype wire

FILE: rtl/rti_in_if.sv
`default_nettype none

interface rti_in_if #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/rti_out_if.sv
`default_nettype none

interface rti_out_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [rti_pkg::DIST_W-1:0]   distance;

    modport source (
        output valid, hit, distance,
        input  ready
    );
    modport sink (
        input  valid, hit, distance,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/rti_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// quo = floor(num * 2^FRAC_W / den), valid when that value is below 2^QUO_W.
module rti_div #(
    parameter int NUM_W  = 42,
    parameter int QUO_W  = 31,
    parameter int FRAC_W = 12
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [NUM_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);
    localparam int DVD_W = NUM_W + FRAC_W + QUO_W;

    logic [DVD_W-1:0] dvd;
    logic [NUM_W-1:0] rem_reg [0:QUO_W-1];
    logic [NUM_W-1:0] den_reg [0:QUO_W-1];
    logic [QUO_W-1:0] low_reg [0:QUO_W-1];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];

    assign dvd = DVD_W'({num, {FRAC_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= NUM_W'(dvd >> QUO_W);
            low_reg[0] <= dvd[QUO_W-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [NUM_W:0] trial;
        logic [NUM_W:0] diff;
        logic           take;

        assign trial = {rem_reg[k], low_reg[k][QUO_W-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign take  = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], take};
            end
        end

        if (k < QUO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
                    low_reg[k+1] <= {low_reg[k][QUO_W-2:0], 1'b0};
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W];

endmodule

`default_nettype wire

FILE: rtl/ray_triangle_intersect.sv
// Ray / triangle intersection (Moller-Trumbore), fixed point. Each input word
// is one ray (origin and direction, signed COORD_BITS with FRAC_BITS fraction
// bits); each output word says whether it hits the configured triangle and,
// on a hit, the ray parameter t (signed, saturated to 32 bits, 0 on miss).
// Fully pipelined: one ray per clock sustained while result words are taken,
// depth at the default settings: 7 arithmetic stages, QUOT_BITS+1 = 32
// divider stages, 1 output register. The three bit-serial dividers (u, v, t)
// set most of that depth. The whole pipe advances together; a held output word
// freezes it, and ray.ready drops only then. Write the vertex and epsilon
// registers only while no ray is in flight.
`default_nettype none

module ray_triangle_intersect #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire rti_pkg::cfg_index_t           cfg_index,
    input  wire logic [rti_pkg::VERTEX_W-1:0]  cfg_data,
    rti_in_if.sink                             ray,
    rti_out_if.source                          res
);
    import rti_pkg::*;

    // Widths along the datapath
    localparam int CW   = COORD_BITS;
    localparam int EW   = CW + 1;                 // edges, s
    localparam int PXW  = CW + EW;                // dir * e2 product
    localparam int PW   = PXW + 1 - FRAC_BITS;    // p components
    localparam int QXW  = 2 * EW;                 // s * e1 product
    localparam int QW   = QXW + 1 - FRAC_BITS;    // q components
    localparam int DEW  = EW + PW;                // e1.p and s.p terms
    localparam int DVW  = CW + QW;                // dir.q terms
    localparam int DTW  = EW + QW;                // e2.q terms
    localparam int NUMW = 3 * CW + 6 - 2 * FRAC_BITS;
    localparam int VXW  = 3 * CW + VERTEX_W;
    localparam int OVW  = NUMW + FRAC_BITS + QUOT_BITS;

    // ---------------- configuration registers ----------------
    logic [VERTEX_W-1:0] vtx1_reg, vtx2_reg, vtx3_reg;
    logic [EPS_W-1:0]    eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx1_reg <= '0;
            vtx2_reg <= '0;
            vtx3_reg <= '0;
            eps_reg  <= EPS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERTEX_ONE:   vtx1_reg <= cfg_data;
                REG_VERTEX_TWO:   vtx2_reg <= cfg_data;
                REG_VERTEX_THREE: vtx3_reg <= cfg_data;
                REG_EPSILON:      eps_reg  <= cfg_data[EPS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Vertex parts; a part reaching past the register reads zeros there
    logic [VXW-1:0]        va_ext, vb_ext, vc_ext;
    logic signed [CW-1:0]  va [3];
    logic signed [CW-1:0]  vb [3];
    logic signed [CW-1:0]  vc [3];
    logic signed [CW-1:0]  org [3];
    logic signed [CW-1:0]  dir [3];

    assign va_ext = VXW'(vtx1_reg);
    assign vb_ext = VXW'(vtx2_reg);
    assign vc_ext = VXW'(vtx3_reg);

    for (genvar k = 0; k < 3; k++)
    begin : g_unpack
        assign va[k] = $signed(va_ext[k*CW +: CW]);
        assign vb[k] = $signed(vb_ext[k*CW +: CW]);
        assign vc[k] = $signed(vc_ext[k*CW +: CW]);
    end

    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign dir[0] = ray.dir_x;
    assign dir[1] = ray.dir_y;
    assign dir[2] = ray.dir_z;

    // ---------------- pipeline control ----------------
    logic out_vld_reg;
    logic en;

    assign en        = !out_vld_reg || res.ready;
    assign ray.ready = en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic vd_reg [0:QUOT_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            for (int i = 0; i <= QUOT_BITS; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= ray.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            vd_reg[0] <= v7_reg;
            for (int i = 1; i <= QUOT_BITS; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            out_vld_reg <= vd_reg[QUOT_BITS];
        end
    end

    // ---------------- S1: edges and s ----------------
    logic signed [CW-1:0] dir1_reg [3];
    logic signed [EW-1:0] e1_1_reg [3];
    logic signed [EW-1:0] e2_1_reg [3];
    logic signed [EW-1:0] s1_reg   [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dir1_reg[k] <= dir[k];
                e1_1_reg[k] <= EW'(vb[k]) - EW'(va[k]);
                e2_1_reg[k] <= EW'(vc[k]) - EW'(va[k]);
                s1_reg[k]   <= EW'(org[k]) - EW'(va[k]);
            end
        end
    end

    // ---------------- S2: cross product terms ----------------
    // p = dir x e2, q = s x e1; [k][0] minus [k][1] gives component k
    logic signed [PXW-1:0] pp_reg [3][2];
    logic signed [QXW-1:0] qp_reg [3][2];
    logic signed [CW-1:0]  dir2_reg [3];
    logic signed [EW-1:0]  e1_2_reg [3];
    logic signed [EW-1:0]  e2_2_reg [3];
    logic signed [EW-1:0]  s2_reg   [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0][0] <= dir1_reg[1] * e2_1_reg[2];
            pp_reg[0][1] <= dir1_reg[2] * e2_1_reg[1];
            pp_reg[1][0] <= dir1_reg[2] * e2_1_reg[0];
            pp_reg[1][1] <= dir1_reg[0] * e2_1_reg[2];
            pp_reg[2][0] <= dir1_reg[0] * e2_1_reg[1];
            pp_reg[2][1] <= dir1_reg[1] * e2_1_reg[0];
            qp_reg[0][0] <= s1_reg[1] * e1_1_reg[2];
            qp_reg[0][1] <= s1_reg[2] * e1_1_reg[1];
            qp_reg[1][0] <= s1_reg[2] * e1_1_reg[0];
            qp_reg[1][1] <= s1_reg[0] * e1_1_reg[2];
            qp_reg[2][0] <= s1_reg[0] * e1_1_reg[1];
            qp_reg[2][1] <= s1_reg[1] * e1_1_reg[0];
            dir2_reg <= dir1_reg;
            e1_2_reg <= e1_1_reg;
            e2_2_reg <= e2_1_reg;
            s2_reg   <= s1_reg;
        end
    end

    // ---------------- S3: cross products, floored ----------------
    logic signed [PXW:0]  pd [3];
    logic signed [QXW:0]  qd [3];
    logic signed [PW-1:0] p3_reg [3];
    logic signed [QW-1:0] q3_reg [3];
    logic signed [CW-1:0] dir3_reg [3];
    logic signed [EW-1:0] e1_3_reg [3];
    logic signed [EW-1:0] e2_3_reg [3];
    logic signed [EW-1:0] s3_reg   [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pd[k] = (PXW+1)'(pp_reg[k][0]) - (PXW+1)'(pp_reg[k][1]);
            qd[k] = (QXW+1)'(qp_reg[k][0]) - (QXW+1)'(qp_reg[k][1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p3_reg[k] <= PW'(pd[k] >>> FRAC_BITS);
                q3_reg[k] <= QW'(qd[k] >>> FRAC_BITS);
            end
            dir3_reg <= dir2_reg;
            e1_3_reg <= e1_2_reg;
            e2_3_reg <= e2_2_reg;
            s3_reg   <= s2_reg;
        end
    end

    // ---------------- S4: dot product terms ----------------
    logic signed [DEW-1:0] det_t_reg [3];
    logic signed [DEW-1:0] un_t_reg  [3];
    logic signed [DVW-1:0] vn_t_reg  [3];
    logic signed [DTW-1:0] tn_t_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                det_t_reg[k] <= e1_3_reg[k] * p3_reg[k];
                un_t_reg[k]  <= s3_reg[k] * p3_reg[k];
                vn_t_reg[k]  <= dir3_reg[k] * q3_reg[k];
                tn_t_reg[k]  <= e2_3_reg[k] * q3_reg[k];
            end
        end
    end

    // ---------------- S5: floored term sums ----------------
    logic signed [NUMW-1:0] det5_reg, un5_reg, vn5_reg, tn5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det5_reg <= NUMW'(det_t_reg[0] >>> FRAC_BITS)
                      + NUMW'(det_t_reg[1] >>> FRAC_BITS)
                      + NUMW'(det_t_reg[2] >>> FRAC_BITS);
            un5_reg  <= NUMW'(un_t_reg[0] >>> FRAC_BITS)
                      + NUMW'(un_t_reg[1] >>> FRAC_BITS)
                      + NUMW'(un_t_reg[2] >>> FRAC_BITS);
            vn5_reg  <= NUMW'(vn_t_reg[0] >>> FRAC_BITS)
                      + NUMW'(vn_t_reg[1] >>> FRAC_BITS)
                      + NUMW'(vn_t_reg[2] >>> FRAC_BITS);
            tn5_reg  <= NUMW'(tn_t_reg[0] >>> FRAC_BITS)
                      + NUMW'(tn_t_reg[1] >>> FRAC_BITS)
                      + NUMW'(tn_t_reg[2] >>> FRAC_BITS);
        end
    end

    // ---------------- S6: magnitudes, signs folded with det ----------------
    logic [NUMW-1:0] det_mag6_reg, un_mag6_reg, vn_mag6_reg, tn_mag6_reg;
    logic            un_neg6_reg, vn_neg6_reg, tn_neg6_reg;
    logic            det_neg;

    assign det_neg = det5_reg[NUMW-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_mag6_reg <= det_neg ? NUMW'(-det5_reg) : NUMW'(det5_reg);
            un_mag6_reg  <= un5_reg[NUMW-1] ? NUMW'(-un5_reg) : NUMW'(un5_reg);
            vn_mag6_reg  <= vn5_reg[NUMW-1] ? NUMW'(-vn5_reg) : NUMW'(vn5_reg);
            tn_mag6_reg  <= tn5_reg[NUMW-1] ? NUMW'(-tn5_reg) : NUMW'(tn5_reg);
            un_neg6_reg  <= un5_reg[NUMW-1] ^ det_neg;
            vn_neg6_reg  <= vn5_reg[NUMW-1] ^ det_neg;
            tn_neg6_reg  <= tn5_reg[NUMW-1] ^ det_neg;
        end
    end

    // ---------------- S7: det test, quotient range checks ----------------
    // quotient >= 2^QUOT_BITS  <=>  n * 2^FRAC_BITS >= d * 2^QUOT_BITS
    function automatic logic quo_ovf(input logic [NUMW-1:0] n,
                                     input logic [NUMW-1:0] d);
        logic [OVW-1:0] lhs;
        logic [OVW-1:0] rhs;
        lhs = OVW'({n, {FRAC_BITS{1'b0}}});
        rhs = OVW'({d, {QUOT_BITS{1'b0}}});
        return lhs >= rhs;
    endfunction

    logic [NUMW-1:0] det_mag7_reg, un_mag7_reg, vn_mag7_reg, tn_mag7_reg;
    rti_side_t       side7_reg;
    rti_side_t       side7_next;

    always_comb
    begin
        side7_next.det_miss = (det_mag6_reg == '0) ||
                              ((NUMW+EPS_W)'(det_mag6_reg) < (NUMW+EPS_W)'(eps_reg));
        side7_next.u_ovf    = quo_ovf(un_mag6_reg, det_mag6_reg);
        side7_next.u_neg    = un_neg6_reg;
        side7_next.v_ovf    = quo_ovf(vn_mag6_reg, det_mag6_reg);
        side7_next.v_neg    = vn_neg6_reg;
        side7_next.t_ovf    = quo_ovf(tn_mag6_reg, det_mag6_reg);
        side7_next.t_neg    = tn_neg6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_mag7_reg <= det_mag6_reg;
            un_mag7_reg  <= un_mag6_reg;
            vn_mag7_reg  <= vn_mag6_reg;
            tn_mag7_reg  <= tn_mag6_reg;
            side7_reg    <= side7_next;
        end
    end

    // ---------------- dividers, flags alongside ----------------
    logic [QUOT_BITS-1:0] qu, qv, qt;
    rti_side_t            side_reg [0:QUOT_BITS];

    rti_div #(.NUM_W(NUMW), .QUO_W(QUOT_BITS), .FRAC_W(FRAC_BITS)) u_div_u (
        .clk (clk),
        .en  (en),
        .num (un_mag7_reg),
        .den (det_mag7_reg),
        .quo (qu)
    );

    rti_div #(.NUM_W(NUMW), .QUO_W(QUOT_BITS), .FRAC_W(FRAC_BITS)) u_div_v (
        .clk (clk),
        .en  (en),
        .num (vn_mag7_reg),
        .den (det_mag7_reg),
        .quo (qv)
    );

    rti_div #(.NUM_W(NUMW), .QUO_W(QUOT_BITS), .FRAC_W(FRAC_BITS)) u_div_t (
        .clk (clk),
        .en  (en),
        .num (tn_mag7_reg),
        .den (det_mag7_reg),
        .quo (qt)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side7_reg;
            for (int i = 1; i <= QUOT_BITS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- final: bounds on u and v, t saturation ----------------
    rti_side_t             sd;
    logic [QUOT_BITS:0]    u_w, v_w, one_w, eps_w, uv_w;
    logic                  miss;
    logic signed [DIST_W-1:0] t_val;
    logic                  hit_next;
    logic signed [DIST_W-1:0] dist_next;
    logic                  hit_reg;
    logic signed [DIST_W-1:0] dist_reg;

    assign sd    = side_reg[QUOT_BITS];
    assign u_w   = (QUOT_BITS+1)'(qu);
    assign v_w   = (QUOT_BITS+1)'(qv);
    assign one_w = (QUOT_BITS+1)'(1) << FRAC_BITS;
    assign eps_w = (QUOT_BITS+1)'(eps_reg);
    assign uv_w  = u_w + v_w;

    always_comb
    begin
        // a negative quotient that truncates to zero reads as zero
        miss = sd.det_miss || sd.u_ovf || (sd.u_neg && (qu != '0)) ||
               (u_w < eps_w) || (u_w > one_w) ||
               sd.v_ovf || (sd.v_neg && (qv != '0)) || (uv_w > one_w);

        if (sd.t_ovf)
        begin
            t_val = sd.t_neg ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
        end
        else if (sd.t_neg)
        begin
            t_val = -$signed(DIST_W'(qt));
        end
        else
        begin
            t_val = $signed(DIST_W'(qt));
        end

        hit_next  = !miss;
        dist_next = miss ? '0 : t_val;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign res.valid    = out_vld_reg;
    assign res.hit      = hit_reg;
    assign res.distance = dist_reg;

endmodule

`default_nettype wire
